@@ rtl/core/grid_diffusion_stencil_assert.svh @@
// ----------------------------------------------------------------------------
// Grid diffusion stencil assertion macros
// Clocked, reset-qualified property checks shared by the stencil RTL.
// ----------------------------------------------------------------------------
`ifndef GRID_DIFFUSION_STENCIL_ASSERT_SVH
`define GRID_DIFFUSION_STENCIL_ASSERT_SVH

// Same-cycle implication on clk_i, disabled while rst_ni is low
`define GDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk_i, disabled while rst_ni is low
`define GDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/gds_pkg.sv @@
// ----------------------------------------------------------------------------
// Grid diffusion stencil package
// Widths, reset values, register map and shared types of the stencil.
// ----------------------------------------------------------------------------
package gds_pkg;

  // Line buffer depth default
  localparam int unsigned MaxWidthDef = 1024;

  // Field widths
  localparam int unsigned ValW     = 32;  // Q16.16 cell
  localparam int unsigned RowW     = 16;
  localparam int unsigned OutColW  = 10;
  localparam int unsigned CfgColsW = 11;
  localparam int unsigned FactorW  = 16;  // Q0.16 factor

  // Arithmetic
  localparam int unsigned NumNb     = 4;
  localparam int unsigned SumW      = ValW + 3;           // four 33-bit differences
  localparam int unsigned ProdW     = SumW + FactorW + 1;
  localparam int unsigned FracShift = 18;                 // Q0.16 plus the quarter
  localparam int unsigned ShW       = ProdW - FracShift;
  localparam int unsigned AccW      = ShW + 1;

  // Result queue
  localparam int unsigned FifoDepth = 8;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned FillW     = $clog2(FifoDepth + 1);
  localparam int unsigned NumRes    = 3;

  // Configuration port
  localparam int unsigned PAddrW   = 4;
  localparam int unsigned ApbDataW = 32;

  localparam logic [RowW-1:0]     RowsRst   = 16'd256;
  localparam logic [CfgColsW-1:0] ColsRst   = 11'd256;
  localparam logic [FactorW-1:0]  FactorRst = 16'd26214;

  typedef enum logic [1:0] {
    RegRows   = 2'd0,
    RegCols   = 2'd1,
    RegFactor = 2'd2
  } reg_idx_e;

  // Which of the four neighbors take part in one result
  typedef struct packed {
    logic up;
    logic left;
    logic right;
    logic down;
  } nb_present_t;

endpackage

@@ rtl/core/gds_diffuse.sv @@
// ----------------------------------------------------------------------------
// Diffusion update datapath
// Sums neighbor differences, scales by the spread factor, floors by 2^18
// and saturates center + delta. Two register stages, result combinational.
// ----------------------------------------------------------------------------
module gds_diffuse import gds_pkg::*; (
  input  logic                       clk_i,
  input  logic [ValW-1:0]            center_i,
  input  logic [NumNb-1:0][ValW-1:0] nb_i,
  input  nb_present_t                present_i,
  input  logic [FactorW-1:0]         factor_i,
  output logic [ValW-1:0]            value_o
);

  logic [NumNb-1:0]        pres;
  logic signed [SumW-1:0]  sum_d, sum_q;
  logic signed [ValW-1:0]  ctr_a_q, ctr_b_q;
  logic signed [ProdW-1:0] prod_d, prod_q;
  logic signed [ShW-1:0]   step;
  logic signed [AccW-1:0]  acc;

  assign pres = present_i;

  // Sum of (neighbor - center) over present neighbors
  always_comb begin
    sum_d = '0;
    for (int k = 0; k < NumNb; k++) begin
      if (pres[k]) begin
        sum_d = sum_d + SumW'($signed(nb_i[k])) - SumW'($signed(center_i));
      end
    end
  end

  // Unsigned factor taken as a non-negative signed operand
  assign prod_d = ProdW'(sum_q) * ProdW'($signed({1'b0, factor_i}));

  always_ff @(posedge clk_i) begin
    sum_q   <= sum_d;
    ctr_a_q <= $signed(center_i);
    prod_q  <= prod_d;
    ctr_b_q <= ctr_a_q;
  end

  // Arithmetic shift floors toward minus infinity
  assign step = ShW'(prod_q >>> FracShift);
  assign acc  = AccW'(ctr_b_q) + AccW'(step);

  // Saturate to the signed 32-bit range
  always_comb begin
    if (!acc[AccW-1] && (|acc[AccW-2:ValW-1])) begin
      value_o = {1'b0, {(ValW-1){1'b1}}};
    end else if (acc[AccW-1] && !(&acc[AccW-2:ValW-1])) begin
      value_o = {1'b1, {(ValW-1){1'b0}}};
    end else begin
      value_o = acc[ValW-1:0];
    end
  end

endmodule

@@ rtl/core/grid_diffusion_stencil.sv @@
// ----------------------------------------------------------------------------
// Grid diffusion stencil
// Streaming five-point explicit diffusion step over a raster grid.
// ----------------------------------------------------------------------------
// Cells enter in raster order, one item per clock with no gaps required. For
// each cell the block gives v + floor(spread_factor * sum(nb - v) / 2^18),
// saturated, with absent outside neighbors (zero flux at the border). Results
// lag one row: the cell at (r, c) releases the result for (r-1, c); on the
// last row each cell also releases its left neighbor, and the frame's last
// cell releases itself, tagged frame_end. The output port moves one result
// per clock while out_stall_i is low; away from the last row the block
// sustains one item per clock while in_stall_o is low. An item's results
// pass the stage 1 registers, the datapath registers and the result queue.
// Two line memories of MaxWidth entries with registered reads hold the previous
// two rows; they need no clearing after reset. A queue of eight result groups
// sits before the output; in_stall_o rises once eight items' results are
// outstanding. The user must write frame_rows, frame_cols and spread_factor
// over the APB port while no item is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "grid_diffusion_stencil_assert.svh"

module grid_diffusion_stencil import gds_pkg::*; #(
  parameter int unsigned MaxWidth = MaxWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PAddrW-1:0]      paddr,
  input  logic [ApbDataW-1:0]    pwdata,
  output logic [ApbDataW-1:0]    prdata,
  output logic                   pready,
  // cell input
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [ValW-1:0] cell_value_i,
  // result output
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [ValW-1:0] out_value_o,
  output logic [RowW-1:0]        out_row_o,
  output logic [OutColW-1:0]     out_col_o,
  output logic                   run_last_o,
  output logic                   frame_end_o
);

  localparam int unsigned CntW = $clog2(MaxWidth);

  typedef struct packed {
    logic r_ge1;
    logic r_ge2;
    logic c_ge1;
    logic c_ge2;
    logic last_row;
    logic last_col;
  } item_flags_t;

  typedef struct packed {
    logic [NumRes-1:0][ValW-1:0] vals;
    logic [RowW-1:0]             row;
    logic [CntW-1:0]             col;
    logic [NumRes-1:0]           mask;
  } bundle_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [RowW-1:0]     frame_rows_q;
  logic [CfgColsW-1:0] frame_cols_q;
  logic [FactorW-1:0]  spread_factor_q;
  logic                cfg_we;
  reg_idx_e            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[PAddrW-1:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_rows_q    <= RowsRst;
      frame_cols_q    <= ColsRst;
      spread_factor_q <= FactorRst;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        RegRows:   frame_rows_q    <= pwdata[RowW-1:0];
        RegCols:   frame_cols_q    <= pwdata[CfgColsW-1:0];
        RegFactor: spread_factor_q <= pwdata[FactorW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegRows:   prdata = ApbDataW'(frame_rows_q);
      RegCols:   prdata = ApbDataW'(frame_cols_q);
      RegFactor: prdata = ApbDataW'(spread_factor_q);
      default:   prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Raster counters and per-item flags
  // --------------------------------------------------------------------------
  logic [RowW-1:0]   row_cnt_q;
  logic [CntW-1:0]   col_cnt_q;
  logic [RowW-1:0]   row_lim;
  logic [CntW-1:0]   col_lim;
  logic              last_row, last_col;
  logic              in_acc;
  logic              acc_has_res;
  logic [CntW-1:0]   newer_raddr;
  item_flags_t       acc_flags;

  // Zero rows or columns act as one; columns clip at the line depth
  always_comb begin
    if (frame_cols_q == '0) begin
      col_lim = '0;
    end else if (int'(frame_cols_q) > int'(MaxWidth)) begin
      col_lim = CntW'(MaxWidth - 1);
    end else begin
      col_lim = CntW'(frame_cols_q - CfgColsW'(1));
    end
    row_lim = (frame_rows_q == '0) ? '0 : frame_rows_q - RowW'(1);
  end

  assign last_row = row_cnt_q >= row_lim;
  assign last_col = col_cnt_q >= col_lim;

  assign acc_flags.r_ge1    = row_cnt_q != '0;
  assign acc_flags.r_ge2    = row_cnt_q > RowW'(1);
  assign acc_flags.c_ge1    = col_cnt_q != '0;
  assign acc_flags.c_ge2    = col_cnt_q > CntW'(1);
  assign acc_flags.last_row = last_row;
  assign acc_flags.last_col = last_col;

  assign acc_has_res = acc_flags.r_ge1 || (last_row && (acc_flags.c_ge1 || last_col));

  assign in_acc = in_valid_i && !in_stall_o;

  // Prefetch the next column's newer cell; wrap to column 0 at row end
  assign newer_raddr = last_col ? '0 : col_cnt_q + CntW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= '0;
      col_cnt_q <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_cnt_q <= '0;
        row_cnt_q <= last_row ? '0 : row_cnt_q + RowW'(1);
      end else begin
        col_cnt_q <= col_cnt_q + CntW'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 item registers
  // --------------------------------------------------------------------------
  logic              s1_valid_q;
  logic [ValW-1:0]   s1_val_q;
  logic [RowW-1:0]   s1_row_q;
  logic [CntW-1:0]   s1_col_q;
  item_flags_t       s1_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_val_q   <= cell_value_i;
      s1_row_q   <= row_cnt_q;
      s1_col_q   <= col_cnt_q;
      s1_flags_q <= acc_flags;
    end
  end

  // --------------------------------------------------------------------------
  // Line memories: older holds row r-2, newer row r-1 ahead of the write.
  // A read at the address written in the same cycle takes the new data.
  // --------------------------------------------------------------------------
  logic [ValW-1:0] older_mem [MaxWidth];
  logic [ValW-1:0] newer_mem [MaxWidth];
  logic [ValW-1:0] older_rd_q;
  logic [ValW-1:0] newer_rd_q;
  logic [ValW-1:0] nb_pre_q;     // newer cell at the current column
  logic [ValW-1:0] up_left_q;    // row r-1 cell one column to the left
  logic [ValW-1:0] left_q;
  logic [ValW-1:0] left_left_q;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      older_mem[s1_col_q] <= nb_pre_q;
      newer_mem[s1_col_q] <= s1_val_q;
    end
    if (in_acc) begin
      older_rd_q <= (s1_valid_q && (s1_col_q == col_cnt_q)) ? nb_pre_q
                                                            : older_mem[col_cnt_q];
      newer_rd_q <= (s1_valid_q && (s1_col_q == newer_raddr)) ? s1_val_q
                                                              : newer_mem[newer_raddr];
    end
  end

  // Neighbor registers carried from one item to the next
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      up_left_q <= nb_pre_q;
      // single-column grid: the next row's newer cell is this one
      nb_pre_q  <= (s1_flags_q.last_col && (s1_col_q == '0)) ? s1_val_q : newer_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      left_left_q <= '0;
    end else if (s1_valid_q) begin
      left_q      <= s1_val_q;
      left_left_q <= left_q;
    end
  end

  // --------------------------------------------------------------------------
  // Three update datapaths: row above, left cell on the last row, own cell
  // --------------------------------------------------------------------------
  logic [NumRes-1:0]           s1_mask;
  logic [NumRes-1:0][ValW-1:0] res_val;
  nb_present_t                 pres_up, pres_left, pres_own;

  assign s1_mask = {s1_flags_q.last_row && s1_flags_q.last_col,
                    s1_flags_q.last_row && s1_flags_q.c_ge1,
                    s1_flags_q.r_ge1};

  assign pres_up   = '{up: s1_flags_q.r_ge2, left: s1_flags_q.c_ge1,
                       right: !s1_flags_q.last_col, down: 1'b1};
  assign pres_left = '{up: s1_flags_q.r_ge1, left: s1_flags_q.c_ge2,
                       right: 1'b1, down: 1'b0};
  assign pres_own  = '{up: s1_flags_q.r_ge1, left: s1_flags_q.c_ge1,
                       right: 1'b0, down: 1'b0};

  gds_diffuse u_diff_up (
    .clk_i     (clk_i),
    .center_i  (nb_pre_q),
    .nb_i      ({older_rd_q, up_left_q, newer_rd_q, s1_val_q}),
    .present_i (pres_up),
    .factor_i  (spread_factor_q),
    .value_o   (res_val[0])
  );

  gds_diffuse u_diff_left (
    .clk_i     (clk_i),
    .center_i  (left_q),
    .nb_i      ({up_left_q, left_left_q, s1_val_q, {ValW{1'b0}}}),
    .present_i (pres_left),
    .factor_i  (spread_factor_q),
    .value_o   (res_val[1])
  );

  gds_diffuse u_diff_own (
    .clk_i     (clk_i),
    .center_i  (s1_val_q),
    .nb_i      ({nb_pre_q, left_q, {ValW{1'b0}}, {ValW{1'b0}}}),
    .present_i (pres_own),
    .factor_i  (spread_factor_q),
    .value_o   (res_val[2])
  );

  // Tags travel alongside the two datapath stages
  logic [NumRes-1:0] m1_mask_q, m2_mask_q;
  logic [RowW-1:0]   m1_row_q, m2_row_q;
  logic [CntW-1:0]   m1_col_q, m2_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_mask_q <= '0;
      m2_mask_q <= '0;
    end else begin
      m1_mask_q <= s1_valid_q ? s1_mask : '0;
      m2_mask_q <= m1_mask_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m1_row_q <= s1_row_q;
    m1_col_q <= s1_col_q;
    m2_row_q <= m1_row_q;
    m2_col_q <= m1_col_q;
  end

  // --------------------------------------------------------------------------
  // Result queue: one group of up to three results per item
  // --------------------------------------------------------------------------
  bundle_t           fifo_mem [FifoDepth];
  bundle_t           head;
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FillW-1:0]  fifo_cnt_q;
  logic [FillW-1:0]  res_q;        // items with results not yet fully sent
  logic [NumRes-1:0] done_q;
  logic [NumRes-1:0] rem, cur;
  logic              push, pop, out_acc, is_last;

  assign push = m2_mask_q != '0;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_mem[wr_ptr_q] <= '{vals: res_val, row: m2_row_q, col: m2_col_q,
                              mask: m2_mask_q};
    end
  end

  assign head        = fifo_mem[rd_ptr_q];
  assign out_valid_o = fifo_cnt_q != '0;
  assign out_acc     = out_valid_o && !out_stall_i;

  // Walk the group's results lowest first
  assign rem     = head.mask & ~done_q;
  assign cur     = {rem[2] && !rem[1] && !rem[0], rem[1] && !rem[0], rem[0]};
  assign is_last = (rem & ~cur) == '0;
  assign pop     = out_acc && is_last;

  always_comb begin
    if (cur[0]) begin
      out_value_o = head.vals[0];
    end else if (cur[1]) begin
      out_value_o = head.vals[1];
    end else begin
      out_value_o = head.vals[2];
    end
    out_row_o   = cur[0] ? head.row - RowW'(1) : head.row;
    out_col_o   = OutColW'(cur[1] ? head.col - CntW'(1) : head.col);
    run_last_o  = is_last;
    frame_end_o = cur[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
      res_q      <= '0;
      done_q     <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (out_acc) begin
        done_q <= is_last ? '0 : (done_q | cur);
      end
      case ({push, pop})
        2'b10:   fifo_cnt_q <= fifo_cnt_q + FillW'(1);
        2'b01:   fifo_cnt_q <= fifo_cnt_q - FillW'(1);
        default: fifo_cnt_q <= fifo_cnt_q;
      endcase
      case ({in_acc && acc_has_res, pop})
        2'b10:   res_q <= res_q + FillW'(1);
        2'b01:   res_q <= res_q - FillW'(1);
        default: res_q <= res_q;
      endcase
    end
  end

  // Room is reserved at accept time, so the queue never overflows
  assign in_stall_o = res_q == FillW'(FifoDepth);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `GDS_ASSERT_IMP(a_fifo_within_reserve, 1'b1, fifo_cnt_q <= res_q,
                  "result queue holds more groups than reserved")
  `GDS_ASSERT_IMP(a_push_has_room, push, fifo_cnt_q < FillW'(FifoDepth),
                  "result group written into a full queue")
  `GDS_ASSERT_NXT(a_col_wraps, in_acc && last_col, col_cnt_q == '0,
                  "column counter did not wrap after the last column")

endmodule

@@ dv/grid_diffusion_stencil_sb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid diffusion stencil scoreboard
// Tracks the line state and registers of the stencil, turns each accepted
// cell item into its expected diffused results and checks the output stream.
// ----------------------------------------------------------------------------
package gds_tb_pkg;
  import gds_pkg::*;

  localparam longint CellMax = (longint'(1) << (ValW - 1)) - 1;
  localparam longint CellMin = -(longint'(1) << (ValW - 1));

  // One diffused cell as it leaves the block
  typedef struct packed {
    logic signed [ValW-1:0] value;
    logic [RowW-1:0]        row;
    logic [OutColW-1:0]     col;
    logic                   run_last;
    logic                   frame_end;
  } cell_result_t;

  class diffusion_scoreboard;
    // register copies
    logic [RowW-1:0]        frame_rows;
    logic [CfgColsW-1:0]    frame_cols;
    logic [FactorW-1:0]     spread;

    // the two previous rows and the last two cells of the current row
    logic signed [ValW-1:0] older_line [MaxWidthDef];
    logic signed [ValW-1:0] newer_line [MaxWidthDef];
    logic signed [ValW-1:0] left_cell;
    logic signed [ValW-1:0] left_left_cell;
    int unsigned            row_idx;
    int unsigned            col_idx;

    cell_result_t           expected_q [$];
    int                     errors;

    function new();
      frame_rows     = RowsRst;
      frame_cols     = ColsRst;
      spread         = FactorRst;
      left_cell      = '0;
      left_left_cell = '0;
      row_idx        = 0;
      col_idx        = 0;
      errors         = 0;
      foreach (older_line[i]) begin
        older_line[i] = '0;
        newer_line[i] = '0;
      end
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    function logic [ApbDataW-1:0] reg_mask(reg_idx_e idx);
      case (idx)
        RegRows:   return (32'd1 << RowW) - 1;
        RegCols:   return (32'd1 << CfgColsW) - 1;
        RegFactor: return (32'd1 << FactorW) - 1;
        default:   return '0;
      endcase
    endfunction

    function void write_reg(reg_idx_e idx, logic [ApbDataW-1:0] data);
      case (idx)
        RegRows:   frame_rows = data[RowW-1:0];
        RegCols:   frame_cols = data[CfgColsW-1:0];
        RegFactor: spread     = data[FactorW-1:0];
        default: ;
      endcase
    endfunction

    function bit at_frame_start();
      return row_idx == 0 && col_idx == 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // v + floor(spread * flux / 2^18), clipped to the cell range
    function logic signed [ValW-1:0] relax(longint center, longint flux);
      longint step, sum;
      step = (flux * longint'(spread)) >>> FracShift;
      sum  = center + step;
      if (sum > CellMax) sum = CellMax;
      if (sum < CellMin) sum = CellMin;
      return sum[ValW-1:0];
    endfunction

    function cell_result_t make_result(logic signed [ValW-1:0] value, int unsigned row,
                                       int unsigned col, bit fend);
      cell_result_t res;
      res.value     = value;
      res.row       = RowW'(row);
      res.col       = OutColW'(col);
      res.run_last  = 1'b0;
      res.frame_end = fend;
      return res;
    endfunction

    // Accepted cell item: queue the results it releases, then advance state
    function void note_cell(logic signed [ValW-1:0] v);
      cell_result_t           batch [$];
      int unsigned            rows_eff, cols_eff, ci, r;
      bit                     last_col, last_row;
      longint                 cv, up, lf, flux;
      logic signed [ValW-1:0] prev_newer;

      rows_eff = (frame_rows == 0) ? 1 : frame_rows;
      cols_eff = (frame_cols == 0) ? 1 : frame_cols;
      if (cols_eff > MaxWidthDef) cols_eff = MaxWidthDef;
      ci       = (col_idx < MaxWidthDef) ? col_idx : MaxWidthDef - 1;
      r        = row_idx;
      // an index at or past a lowered limit counts as the last one
      last_col = ci >= cols_eff - 1;
      last_row = r >= rows_eff - 1;
      prev_newer = newer_line[ci];
      cv = v;

      // cell one row up now has its lower neighbor
      if (r >= 1) begin
        up   = prev_newer;
        flux = cv - up;
        if (r >= 2) flux += longint'(older_line[ci]) - up;
        if (ci >= 1) flux += longint'(older_line[ci - 1]) - up;
        if (ci + 1 < cols_eff) flux += longint'(newer_line[ci + 1]) - up;
        batch.push_back(make_result(relax(up, flux), r - 1, ci, 1'b0));
      end
      // last row: the left neighbor is complete
      if (last_row && ci >= 1) begin
        lf   = left_cell;
        flux = cv - lf;
        if (r >= 1) flux += longint'(older_line[ci - 1]) - lf;
        if (ci >= 2) flux += longint'(left_left_cell) - lf;
        batch.push_back(make_result(relax(lf, flux), r, ci - 1, 1'b0));
      end
      // final cell of the frame releases itself
      if (last_row && last_col) begin
        flux = 0;
        if (r >= 1) flux += longint'(prev_newer) - cv;
        if (ci >= 1) flux += longint'(left_cell) - cv;
        batch.push_back(make_result(relax(cv, flux), r, ci, 1'b1));
      end
      if (batch.size() > 0) batch[batch.size() - 1].run_last = 1'b1;
      foreach (batch[i]) expected_q.push_back(batch[i]);

      older_line[ci] = prev_newer;
      newer_line[ci] = v;
      left_left_cell = left_cell;
      left_cell      = v;
      if (last_col) begin
        col_idx = 0;
        row_idx = last_row ? 0 : ((r + 1) & 32'hFFFF);
      end else begin
        col_idx = ci + 1;
      end
    endfunction

    // Compare one output result with the oldest expectation
    task check_result(logic signed [ValW-1:0] value, logic [RowW-1:0] row,
                      logic [OutColW-1:0] col, logic run_last, logic frame_end);
      cell_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result row %0d col %0d value %0d",
                                  row, col, value));
      end else begin
        want = expected_q.pop_front();
        if (value !== want.value)
          report_mismatch($sformatf("value at (%0d,%0d): got %0d, want %0d",
                                    want.row, want.col, value, want.value));
        if (row !== want.row)
          report_mismatch($sformatf("row: got %0d, want %0d", row, want.row));
        if (col !== want.col)
          report_mismatch($sformatf("col at row %0d: got %0d, want %0d",
                                    want.row, col, want.col));
        if (run_last !== want.run_last)
          report_mismatch($sformatf("run_last at (%0d,%0d): got %0b, want %0b",
                                    want.row, want.col, run_last, want.run_last));
        if (frame_end !== want.frame_end)
          report_mismatch($sformatf("frame_end at (%0d,%0d): got %0b, want %0b",
                                    want.row, want.col, frame_end, want.frame_end));
      end
    endtask
  endclass

endpackage

@@ dv/grid_diffusion_stencil_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid diffusion stencil testbench
// Streams raster frames of Q16.16 cells through the stencil under random
// sender gaps and receiver stalls, reprograms frame size and spread factor
// between frames and frame size mid-frame, and checks every result in order.
// ----------------------------------------------------------------------------
module grid_diffusion_stencil_tb;
  import gds_pkg::*;
  import gds_tb_pkg::*;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned DrainBound   = 20000;
  localparam int unsigned ItemTarget   = 355;  // directed part plus random frames

  logic                   clk_i;
  logic                   rst_ni;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PAddrW-1:0]      paddr;
  logic [ApbDataW-1:0]    pwdata;
  logic [ApbDataW-1:0]    prdata;
  logic                   pready;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic signed [ValW-1:0] cell_value_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic signed [ValW-1:0] out_value_o;
  logic [RowW-1:0]        out_row_o;
  logic [OutColW-1:0]     out_col_o;
  logic                   run_last_o;
  logic                   frame_end_o;

  diffusion_scoreboard sb;
  int unsigned         cells_sent;
  int unsigned         cycle_count;
  int unsigned         burst_left;
  int unsigned         cur_rows;
  int unsigned         cur_cols;
  bit                  no_gaps;
  bit                  hold_req;

  grid_diffusion_stencil uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cell_value_i (cell_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_value_o  (out_value_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .run_last_o   (run_last_o),
    .frame_end_o  (frame_end_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0)
      sb.check_result(out_value_o, out_row_o, out_col_o, run_last_o, frame_end_o);
  end

  // Receiver: random stall segments, plus one long hold on request
  initial begin
    int unsigned hold_left, seg_left, seg_kind;
    bit          hold_taken;
    hold_left  = 0;
    seg_left   = 0;
    seg_kind   = 0;
    hold_taken = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_left  = HoldCycles;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_kind = $urandom_range(0, 3);
          seg_left = $urandom_range(1, 60);
        end
        seg_left--;
        case (seg_kind)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= 1'($urandom_range(0, 1));
          default: out_stall_i <= (seg_left % 4 == 0);
        endcase
      end
    end
  end

  function automatic logic signed [ValW-1:0] pick_cell();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFFFFFF;
      1:       return 32'sh80000000;
      2, 3, 4: return $urandom;
      default: return $signed($urandom) >>> $urandom_range(4, 15);
    endcase
  endfunction

  task automatic idle_for(int unsigned n);
    in_valid_i   <= 1'b0;
    cell_value_i <= $urandom;
    repeat (n) @(posedge clk_i);
  endtask

  // Offer one cell item and hold it until accepted
  task automatic send_cell(logic signed [ValW-1:0] v);
    in_valid_i   <= 1'b1;
    cell_value_i <= v;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_cell(v);
    cells_sent++;
  endtask

  // Burst pacing of the sender
  task automatic pace();
    int unsigned gap;
    if (!no_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 32);
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 3);
        if (gap > 0) idle_for(gap);
      end
      burst_left--;
    end
  endtask

  task automatic send_cells(int unsigned n);
    repeat (n) begin
      pace();
      send_cell(pick_cell());
    end
  endtask

  task automatic finish_frame();
    do begin
      pace();
      send_cell(pick_cell());
    end while (!sb.at_frame_start());
  endtask

  // Stop sending, wait for all results, then let the pipeline empty
  task automatic drain();
    int unsigned waited;
    in_valid_i   <= 1'b0;
    cell_value_i <= $urandom;
    waited = 0;
    while (sb.pending() != 0 && waited < DrainBound) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // APB write with junk in the unused bits, then read back
  task automatic program_reg(reg_idx_e idx, logic [ApbDataW-1:0] val);
    logic [ApbDataW-1:0] mask, word;
    mask = sb.reg_mask(idx);
    word = (val & mask) | ($urandom & ~mask);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PAddrW'({idx, 2'b00});
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    sb.write_reg(idx, word);
    case (idx)
      RegRows: cur_rows = (word[RowW-1:0] == 0) ? 1 : word[RowW-1:0];
      RegCols: begin
        cur_cols = word[CfgColsW-1:0];
        if (cur_cols == 0) cur_cols = 1;
        if (cur_cols > MaxWidthDef) cur_cols = MaxWidthDef;
      end
      default: ;
    endcase
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata !== (word & mask))
      sb.report_mismatch($sformatf("register %s reads %0h, want %0h",
                                   idx.name(), prdata, word & mask));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_frame(int unsigned rows, int unsigned cols, int unsigned factor);
    drain();
    program_reg(RegRows, rows);
    program_reg(RegCols, cols);
    program_reg(RegFactor, factor);
  endtask

  // One random frame, sometimes with a limit lowered part way through
  task automatic random_frame();
    int unsigned r, c, f;
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 5))
        0:       c = 0;
        1:       c = $urandom_range(16, 48);
        default: c = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
        0:       r = 0;
        1:       r = $urandom_range(6, 10);
        default: r = $urandom_range(1, 4);
      endcase
      if (c > 8) r = $urandom_range(1, 2);
      case ($urandom_range(0, 5))
        0:       f = 0;
        1:       f = 16'hFFFF;
        default: f = $urandom_range(0, 65535);
      endcase
      set_frame(r, c, f);
    end
    if (cur_rows * cur_cols > 1 && $urandom_range(0, 4) == 0) begin
      send_cells($urandom_range(1, cur_rows * cur_cols - 1));
      drain();
      if ($urandom_range(0, 1) == 1 && cur_cols > 1)
        program_reg(RegCols, $urandom_range(1, cur_cols - 1));
      else
        program_reg(RegRows, $urandom_range(1, cur_rows));
    end
    finish_frame();
  endtask

  initial begin
    logic [ValW-1:0] corners [12];
    corners = '{32'h7FFFFFFF, 32'h80000000, 32'h00000000, 32'hFFFFFFFF,
                32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h00000000,
                32'h7FFFFFFF, 32'h00000000, 32'h80000000, 32'h7FFFFFFF};
    sb = new();
    cells_sent   = 0;
    burst_left   = 0;
    cur_rows     = RowsRst;
    cur_cols     = ColsRst;
    rst_ni       <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_valid_i   <= 1'b0;
    cell_value_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corner heights on a small grid at full spread
    set_frame(3, 4, 16'hFFFF);
    foreach (corners[i]) begin
      pace();
      send_cell(corners[i]);
    end

    // zero rows and zero columns give one-cell frames; no spread
    set_frame(0, 0, 0);
    send_cell(32'sh7FFFFFFF);
    send_cell(32'sh80000000);

    // oversized column count, then lowered below the current column
    set_frame(1, 2047, 32768);
    send_cells(4);
    drain();
    program_reg(RegCols, 2);
    finish_frame();

    // row count lowered below the current row
    set_frame(65535, 2, 1);
    send_cells(4);
    drain();
    program_reg(RegRows, 1);
    finish_frame();

    // long output hold under back-to-back items, then a mid-frame pause
    set_frame(4, 12, $urandom_range(0, 65535));
    hold_req = 1'b1;
    no_gaps  = 1'b1;
    send_cells(30);
    no_gaps  = 1'b0;
    drain();
    finish_frame();

    // random frames
    while (cells_sent < ItemTarget) random_frame();

    drain();
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
